FILE: rtl/nsr_pkg.sv
// Package for the Newton square root unit: field widths, status codes and
// register reset values. No dependencies.
package nsr_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned XW          = 32;
  localparam int unsigned StepsW      = 17;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned ProdW       = 64;
  localparam int unsigned SlopeW      = 33;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_FLAT      = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_TARGET = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TOL    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAXIT  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_MINSL  = 2'd3;

  localparam logic [30:0] TARGET_RST = 31'd262144;
  localparam logic [31:0] TOL_RST    = 32'd4295;
  localparam logic [15:0] MAXIT_RST  = 16'd1000;
  localparam logic [15:0] MINSL_RST  = 16'd1;

endpackage

FILE: rtl/nsr_if.sv
// Valid/ready channel interfaces for the guess input and the result output.
// Depends on nsr_pkg.
interface nsr_in_if;
  import nsr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] initial_guess;
  modport source (output valid, output initial_guess, input ready);
  modport sink (input valid, input initial_guess, output ready);
endinterface

interface nsr_out_if;
  import nsr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] root;
  logic [1:0]           status;
  logic [StepsW-1:0]    steps_taken;
  modport source (output valid, output root, output status, output steps_taken, input ready);
  modport sink (input valid, input root, input status, input steps_taken, output ready);
endinterface

FILE: rtl/nsr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Self-contained; used by the Newton square root unit.
module nsr_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 33
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);
  localparam int unsigned CntW = $clog2(NW);

  logic [NW-1:0]   n_q, n_d;
  logic [DW-1:0]   r_q, r_d;
  logic [DW-1:0]   dv_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DW:0]     rs;
  logic [DW:0]     rsub;

  always_comb begin
    rs   = {r_q, n_q[NW-1]};
    rsub = rs - {1'b0, dv_q};
    if (!rsub[DW]) begin
      r_d = rsub[DW-1:0];
      n_d = {n_q[NW-2:0], 1'b1};
    end else begin
      r_d = rs[DW-1:0];
      n_d = {n_q[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q  <= dividend_i;
      r_q  <= '0;
      dv_q <= divisor_i;
    end else if (busy_q) begin
      n_q <= n_d;
      r_q <= r_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = n_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q)) else $error("divider done without a run");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("divider done held");

endmodule

FILE: rtl/newton_square_root_unit.sv
// Newton square root unit: iterates x - (x*x - c)/(2x) on a Q16.16 guess.
// Each step runs a check, the serial square and tolerance product, a divider
// start, the bit-serial divide and an update. A result is registered to the
// output after the last step; the unit waits while an earlier result is held
// unaccepted, and takes the next guess once the result is valid. Reset clears
// control and loads register defaults. Depends on nsr_pkg, nsr_if and nsr_div.
module newton_square_root_unit #(
  parameter int unsigned FRAC_BITS = nsr_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nsr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nsr_pkg::CfgDataW-1:0] cfg_data_i,
  nsr_in_if.sink                       in_i,
  nsr_out_if.source                    out_o
);
  import nsr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_MUL, S_VAL, S_DIV, S_UPD, S_FIN
  } state_e;

  state_e              state_q;
  logic [30:0]         target_q;
  logic [31:0]         tol_q;
  logic [15:0]         maxit_q, minsl_q;
  logic signed [XW-1:0] x_q;
  logic [31:0]         mplier_q;
  logic [ProdW-1:0]    sq_q, bnd_q;
  logic [4:0]          cnt_q;
  logic [StepsW-1:0]   iter_q;
  logic                neg_q;
  logic signed [XW-1:0] res_root_q;
  logic [1:0]          res_status_q;
  logic [StepsW-1:0]   res_steps_q;
  logic                out_valid_q;
  logic signed [XW-1:0] out_root_q;
  logic [1:0]          out_status_q;
  logic [StepsW-1:0]   out_steps_q;

  logic [31:0]         ax;
  logic [SlopeW-1:0]   slope_mag;
  logic signed [ProdW-1:0] c_wide, value;
  logic [ProdW-1:0]    value_mag;
  logic                div_start, div_busy, div_done;
  logic [ProdW-1:0]    quot;
  logic signed [65:0]  xw;
  logic signed [XW-1:0] xnew;
  logic signed [XW:0]  dx;
  logic [XW:0]         diff;
  logic                conv;

  assign ax        = x_q[XW-1] ? 32'(-x_q) : 32'(x_q);
  assign slope_mag = {ax, 1'b0};
  assign c_wide    = ProdW'(target_q) << FRAC_BITS;
  assign value     = $signed(sq_q) - c_wide;
  assign value_mag = value[ProdW-1] ? ProdW'(-value) : ProdW'(value);
  assign div_start = (state_q == S_VAL);

  always_comb begin
    if (neg_q) begin
      xw = 66'(x_q) + $signed({2'b00, quot});
    end else begin
      xw = 66'(x_q) - $signed({2'b00, quot});
    end
    if (xw > 66'sh7FFFFFFF) begin
      xnew = 32'sh7FFFFFFF;
    end else if (xw < -66'sh80000000) begin
      xnew = 32'sh80000000;
    end else begin
      xnew = xw[XW-1:0];
    end
    dx   = 33'(xnew) - 33'(x_q);
    diff = dx[XW] ? 33'(-dx) : 33'(dx);
    conv = !diff[XW] && ({diff[31:0], 32'b0} < bnd_q);
  end

  nsr_div #(.NW(ProdW), .DW(SlopeW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (value_mag),
    .divisor_i  (slope_mag),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      tol_q    <= TOL_RST;
      maxit_q  <= MAXIT_RST;
      minsl_q  <= MINSL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET: target_q <= cfg_data_i[30:0];
        REG_TOL:    tol_q    <= cfg_data_i;
        REG_MAXIT:  maxit_q  <= cfg_data_i[15:0];
        REG_MINSL:  minsl_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            x_q    <= in_i.initial_guess;
            iter_q <= '0;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (iter_q > {1'b0, maxit_q}) begin
            res_root_q   <= x_q;
            res_status_q <= ST_LIMIT;
            res_steps_q  <= iter_q;
            state_q      <= S_FIN;
          end else if (ax == '0 || slope_mag < SlopeW'(minsl_q)) begin
            res_root_q   <= x_q;
            res_status_q <= ST_FLAT;
            res_steps_q  <= iter_q;
            state_q      <= S_FIN;
          end else begin
            mplier_q <= ax;
            sq_q     <= '0;
            bnd_q    <= '0;
            cnt_q    <= '0;
            state_q  <= S_MUL;
          end
        end
        S_MUL: begin
          sq_q     <= {sq_q[ProdW-2:0], 1'b0} + (mplier_q[31] ? ProdW'(ax) : '0);
          bnd_q    <= {bnd_q[ProdW-2:0], 1'b0} + (mplier_q[31] ? ProdW'(tol_q) : '0);
          mplier_q <= {mplier_q[30:0], 1'b0};
          cnt_q    <= cnt_q + 1'b1;
          if (cnt_q == 5'd31) begin
            state_q <= S_VAL;
          end
        end
        S_VAL: begin
          neg_q   <= value[ProdW-1] ^ x_q[XW-1];
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (conv) begin
            res_root_q   <= xnew;
            res_status_q <= ST_CONVERGED;
            res_steps_q  <= iter_q + 1'b1;
            state_q      <= S_FIN;
          end else begin
            x_q     <= xnew;
            iter_q  <= iter_q + 1'b1;
            state_q <= S_CHECK;
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_root_q   <= res_root_q;
            out_status_q <= res_status_q;
            out_steps_q  <= res_steps_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.root        = out_root_q;
  assign out_o.status      = out_status_q;
  assign out_o.steps_taken = out_steps_q;

  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !div_busy) else $error("input ready while divider runs");
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("quotient outside divide state");
  a_conv_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_CONVERGED) |-> out_o.steps_taken != '0)
    else $error("converged result with no step");

endmodule
